// ===== src/eip_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the Ethernet / IPv4 / L4 header parser.
// No dependencies.
package eip_pkg;

  localparam int unsigned EthHdrBytesDef = 14;
  localparam logic [31:0] LanMaskReset   = 32'hFFFF_FF00;
  localparam logic [6:0]  OffsetMax      = 7'd127;
  localparam logic [5:0]  IpMinHdr       = 6'd20;
  localparam logic [5:0]  TcpMinHdr      = 6'd20;
  localparam logic [15:0] EtherTypeIpv4  = 16'h0800;
  localparam logic [7:0]  IpProtoIcmp    = 8'd1;
  localparam logic [7:0]  IpProtoIgmp    = 8'd2;
  localparam logic [7:0]  IpProtoTcp     = 8'd6;
  localparam logic [7:0]  IpProtoUdp     = 8'd17;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_NOT_IPV4  = 3'd1,
    STS_BAD_IPHL  = 3'd2,
    STS_LOCAL     = 3'd3,
    STS_BAD_TCPHL = 3'd4,
    STS_TRUNC     = 3'd5
  } eip_status_e;

  typedef enum logic [2:0] {
    PC_TCP   = 3'd0,
    PC_UDP   = 3'd1,
    PC_ICMP  = 3'd2,
    PC_IGMP  = 3'd3,
    PC_OTHER = 3'd4
  } eip_proto_e;

  // Header fields captured so far in the current frame.
  typedef struct packed {
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic [15:0] ether_kind;
    logic [3:0]  ihl;
    logic [15:0] total_len;
    logic [7:0]  proto;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [3:0]  tcp_doff;
  } eip_frame_t;

  // Capture stage to result stage.
  typedef struct packed {
    logic       fire;
    logic [6:0] offset;
    eip_frame_t frame;
  } eip_fin_t;

endpackage

// ===== src/eip_frame_if.sv =====
`timescale 1ns / 1ps
// Byte stream channel carrying one frame byte per transaction.
// No dependencies.
interface eip_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;

  modport source (output valid, frame_byte, frame_end, input ready);
  modport sink   (input valid, frame_byte, frame_end, output ready);
endinterface

// ===== src/eip_result_if.sv =====
`timescale 1ns / 1ps
// Result channel carrying one parsed header summary per transaction.
// No dependencies.
interface eip_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  parse_status;
  logic [47:0] dst_mac;
  logic [47:0] src_mac;
  logic [31:0] src_ip;
  logic [31:0] dst_ip;
  logic [5:0]  ip_header_len;
  logic [15:0] ip_total_len;
  logic [2:0]  proto_class;
  logic [5:0]  tcp_header_len;
  logic [15:0] sport;
  logic [15:0] dport;

  modport source (output valid, parse_status, dst_mac, src_mac, src_ip, dst_ip,
                  ip_header_len, ip_total_len, proto_class, tcp_header_len,
                  sport, dport, input ready);
  modport sink   (input valid, parse_status, dst_mac, src_mac, src_ip, dst_ip,
                  ip_header_len, ip_total_len, proto_class, tcp_header_len,
                  sport, dport, output ready);
endinterface

// ===== src/eip_capture.sv =====
`timescale 1ns / 1ps
// Input register, byte offset counter and header field capture.
// Depends on eip_pkg and eip_frame_if.
module eip_capture #(
  parameter int unsigned ETH_HDR_BYTES = eip_pkg::EthHdrBytesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  eip_frame_if.sink         frame_i,
  input  logic              slot_free_i,
  output eip_pkg::eip_fin_t fin_o
);
  import eip_pkg::*;

  localparam logic [6:0] EthHdr = 7'(ETH_HDR_BYTES);

  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       end_q;
  logic       adv;

  logic [6:0] offset_q, offset_d;
  eip_frame_t frame_q, frame_d, cap;

  logic [6:0] q_off;
  logic [6:0] r_off;
  logic [5:0] hl;
  logic [1:0] lane;

  assign adv           = in_valid_q & (~end_q | slot_free_i);
  assign frame_i.ready = ~in_valid_q | adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (frame_i.valid && frame_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_i.valid && frame_i.ready) begin
      byte_q <= frame_i.frame_byte;
      end_q  <= frame_i.frame_end;
    end
  end

  always_comb begin
    cap   = frame_q;
    q_off = offset_q - EthHdr;
    hl    = {frame_q.ihl, 2'b00};
    r_off = q_off - {1'b0, hl};
    lane  = ~q_off[1:0];
    if (offset_q < OffsetMax) begin
      if (offset_q < 7'd6) begin
        cap.dst_mac = {frame_q.dst_mac[39:0], byte_q};
      end else if (offset_q < 7'd12) begin
        cap.src_mac = {frame_q.src_mac[39:0], byte_q};
      end
      if (offset_q == EthHdr - 7'd2) begin
        cap.ether_kind[15:8] = byte_q;
      end else if (offset_q == EthHdr - 7'd1) begin
        cap.ether_kind[7:0] = byte_q;
      end
      if (offset_q >= EthHdr) begin
        if (q_off == 7'd0) begin
          cap.ihl = byte_q[3:0];
        end else if (q_off == 7'd2) begin
          cap.total_len[15:8] = byte_q;
        end else if (q_off == 7'd3) begin
          cap.total_len[7:0] = byte_q;
        end else if (q_off == 7'd9) begin
          cap.proto = byte_q;
        end else if (q_off >= 7'd12 && q_off < 7'd16) begin
          cap.src_ip[{lane, 3'b000} +: 8] = byte_q;
        end else if (q_off >= 7'd16 && q_off < 7'd20) begin
          cap.dst_ip[{lane, 3'b000} +: 8] = byte_q;
        end
        // L4 header starts once the IP header length is known and valid
        if (hl >= IpMinHdr && q_off >= {1'b0, hl}) begin
          if (r_off == 7'd0) begin
            cap.sport[15:8] = byte_q;
          end else if (r_off == 7'd1) begin
            cap.sport[7:0] = byte_q;
          end else if (r_off == 7'd2) begin
            cap.dport[15:8] = byte_q;
          end else if (r_off == 7'd3) begin
            cap.dport[7:0] = byte_q;
          end else if (r_off == 7'd12) begin
            cap.tcp_doff = byte_q[7:4];
          end
        end
      end
    end
  end

  always_comb begin
    frame_d  = frame_q;
    offset_d = offset_q;
    if (adv) begin
      if (end_q) begin
        frame_d  = '0;
        offset_d = '0;
      end else begin
        frame_d = cap;
        if (offset_q < OffsetMax) begin
          offset_d = offset_q + 7'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q  <= '0;
      offset_q <= '0;
    end else begin
      frame_q  <= frame_d;
      offset_q <= offset_d;
    end
  end

  assign fin_o.fire   = adv & end_q;
  assign fin_o.offset = offset_q;
  assign fin_o.frame  = cap;

endmodule

// ===== src/eip_result.sv =====
`timescale 1ns / 1ps
// Frame checks, status and result register feeding the output channel.
// Depends on eip_pkg and eip_result_if.
module eip_result #(
  parameter int unsigned ETH_HDR_BYTES = eip_pkg::EthHdrBytesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  eip_pkg::eip_fin_t fin_i,
  input  logic [31:0]       lan_mask_i,
  output logic              slot_free_o,
  eip_result_if.source      result_o
);
  import eip_pkg::*;

  localparam logic [7:0] EthLen = 8'(ETH_HDR_BYTES);

  logic        out_valid_q;
  eip_status_e sts_d, sts_q;
  eip_proto_e  cls_d, cls_q;
  logic [47:0] dst_mac_d, dst_mac_q, src_mac_d, src_mac_q;
  logic [31:0] src_ip_d, src_ip_q, dst_ip_d, dst_ip_q;
  logic [5:0]  iphl_d, iphl_q, tcphl_d, tcphl_q;
  logic [15:0] tlen_d, tlen_q, sport_d, sport_q, dport_d, dport_q;

  logic [7:0]  len;
  logic [5:0]  hl;
  logic [5:0]  th;
  logic [7:0]  l4_base;
  eip_proto_e  cls;
  eip_frame_t  f;

  assign slot_free_o = ~out_valid_q | result_o.ready;

  always_comb begin
    f       = fin_i.frame;
    len     = {1'b0, fin_i.offset} + 8'd1;
    hl      = {f.ihl, 2'b00};
    th      = {f.tcp_doff, 2'b00};
    l4_base = EthLen + {2'b00, hl};
    if (f.proto == IpProtoTcp) begin
      cls = PC_TCP;
    end else if (f.proto == IpProtoUdp) begin
      cls = PC_UDP;
    end else if (f.proto == IpProtoIcmp) begin
      cls = PC_ICMP;
    end else if (f.proto == IpProtoIgmp) begin
      cls = PC_IGMP;
    end else begin
      cls = PC_OTHER;
    end

    sts_d     = STS_OK;
    cls_d     = PC_TCP;
    dst_mac_d = '0;
    src_mac_d = '0;
    src_ip_d  = '0;
    dst_ip_d  = '0;
    iphl_d    = '0;
    tlen_d    = '0;
    tcphl_d   = '0;
    sport_d   = '0;
    dport_d   = '0;

    if (len < EthLen) begin
      sts_d = STS_TRUNC;
    end else if (f.ether_kind != EtherTypeIpv4) begin
      sts_d = STS_NOT_IPV4;
    end else if (len < EthLen + 8'd1) begin
      sts_d = STS_TRUNC;
    end else if (hl < IpMinHdr) begin
      sts_d = STS_BAD_IPHL;
    end else if (len < EthLen + {2'b00, IpMinHdr}) begin
      sts_d = STS_TRUNC;
    end else if (((f.src_ip ^ f.dst_ip) & lan_mask_i) == 32'd0) begin
      sts_d = STS_LOCAL;
    end else if ((cls == PC_TCP && len < l4_base + 8'd13) ||
                 (cls == PC_UDP && len < l4_base + 8'd4)) begin
      sts_d = STS_TRUNC;
    end else begin
      dst_mac_d = f.dst_mac;
      src_mac_d = f.src_mac;
      src_ip_d  = f.src_ip;
      dst_ip_d  = f.dst_ip;
      iphl_d    = hl;
      tlen_d    = f.total_len;
      cls_d     = cls;
      if (cls == PC_TCP) begin
        if (th < TcpMinHdr) begin
          sts_d = STS_BAD_TCPHL;
        end else begin
          tcphl_d = th;
          sport_d = f.sport;
          dport_d = f.dport;
        end
      end else if (cls == PC_UDP) begin
        sport_d = f.sport;
        dport_d = f.dport;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_i.fire) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_i.fire) begin
      sts_q     <= sts_d;
      cls_q     <= cls_d;
      dst_mac_q <= dst_mac_d;
      src_mac_q <= src_mac_d;
      src_ip_q  <= src_ip_d;
      dst_ip_q  <= dst_ip_d;
      iphl_q    <= iphl_d;
      tlen_q    <= tlen_d;
      tcphl_q   <= tcphl_d;
      sport_q   <= sport_d;
      dport_q   <= dport_d;
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.parse_status   = sts_q;
  assign result_o.dst_mac        = dst_mac_q;
  assign result_o.src_mac        = src_mac_q;
  assign result_o.src_ip         = src_ip_q;
  assign result_o.dst_ip         = dst_ip_q;
  assign result_o.ip_header_len  = iphl_q;
  assign result_o.ip_total_len   = tlen_q;
  assign result_o.proto_class    = cls_q;
  assign result_o.tcp_header_len = tcphl_q;
  assign result_o.sport          = sport_q;
  assign result_o.dport          = dport_q;

endmodule

// ===== src/eth_ipv4_l4_header_parser.sv =====
`timescale 1ns / 1ps
// Top level of the Ethernet / IPv4 / TCP / UDP header parser.
// Depends on eip_pkg, eip_frame_if, eip_result_if, eip_capture and eip_result.
//
// Takes one frame byte per cycle, starting at the destination MAC, with
// frame_end on the last byte; bytes past position 126 are ignored. Each byte
// passes through an input register and is captured from there; on the last
// byte the checks run in the same cycle and one result transaction is loaded
// into the output register when it is free or being emptied, so the last byte
// passes the input and then the output register before the result shows.
// Throughput is one byte per cycle; ready drops only while a finished result
// waits in the output register and the registered byte is itself a frame end.
// The user must write lan_mask through cfg_we_i / cfg_wdata_i only between
// frames; the block itself does not enforce it. It resets to 0xFFFFFF00.
module eth_ipv4_l4_header_parser #(
  parameter int unsigned ETH_HDR_BYTES = eip_pkg::EthHdrBytesDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [31:0]  cfg_wdata_i,
  eip_frame_if.sink    frame_i,
  eip_result_if.source result_o
);
  import eip_pkg::*;

  logic [31:0] lan_mask_q;
  logic        slot_free;
  eip_fin_t    fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lan_mask_q <= LanMaskReset;
    end else if (cfg_we_i) begin
      lan_mask_q <= cfg_wdata_i;
    end
  end

  eip_capture #(
    .ETH_HDR_BYTES (ETH_HDR_BYTES)
  ) u_capture (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .frame_i     (frame_i),
    .slot_free_i (slot_free),
    .fin_o       (fin)
  );

  eip_result #(
    .ETH_HDR_BYTES (ETH_HDR_BYTES)
  ) u_result (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fin_i       (fin),
    .lan_mask_i  (lan_mask_q),
    .slot_free_o (slot_free),
    .result_o    (result_o)
  );

  a_fire_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin.fire |-> (!result_o.valid || result_o.ready))
    else $error("frame end fired into an occupied result register");

  a_fire_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin.fire |=> result_o.valid)
    else $error("result not presented after frame end");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> (result_o.parse_status <= STS_TRUNC))
    else $error("status code out of range");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.parse_status != STS_OK &&
     result_o.parse_status != STS_BAD_TCPHL) |->
    (result_o.dst_mac == 48'd0 && result_o.src_ip == 32'd0 &&
     result_o.sport == 16'd0))
    else $error("rejected frame carries header fields");

endmodule
